/* design/cbe_pkg.sv */
// Shared constants, types and helpers for the constant modulus blind equaliser.
// Used by cbe_cell, cbe_tap_unit and cma_blind_equalizer_top; no dependencies.
package cbe_pkg;

	localparam int TAPS      = 32;
	localparam int W_W       = 24;                    // weight / output width, Q4.20
	localparam int X_W       = 16;                    // sample width, Q1.15
	localparam int MUE_W     = 48;                    // step size times error
	localparam int PROD_W    = MUE_W + X_W;           // shared multiplier product
	localparam int ACC_W     = W_W + X_W + 1 + $clog2(TAPS);
	localparam int RC_W      = $clog2(TAPS + 2);      // rotation counter
	localparam int SAT_IN_W  = 36;                    // input width of the saturator
	localparam int STEP_W    = 16;

	localparam logic [STEP_W-1:0]      STEP_RST = STEP_W'(328);
	localparam logic signed [W_W-1:0] ONE_Q20  = W_W'(1048576);
	localparam logic signed [W_W-1:0] W_MAX    = W_W'(8388607);
	localparam logic signed [W_W-1:0] W_MIN    = W_W'(-8388608);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_DOT  = 7'b0000010,
		ST_Y    = 7'b0000100,
		ST_SQ   = 7'b0001000,
		ST_ERR  = 7'b0010000,
		ST_MUE  = 7'b0100000,
		ST_UPD  = 7'b1000000
	} state_t;

	// Controls broadcast to every cell of the ring.
	typedef struct packed {
		logic load;    // shift a new sample into the delay line
		logic rotate;  // pass weight and sample one place towards the head
		logic clear;   // restore the reset contents
	} cell_ctl_t;

	// Controls for the shared multiply unit at the head of the ring.
	typedef struct packed {
		logic active;  // a rotation cycle is in progress
		logic real_el; // the head cell holds a real tap this cycle
		logic update;  // weight update pass rather than dot product pass
	} tap_ctl_t;

	function automatic logic signed [W_W-1:0] sat_w(input logic signed [SAT_IN_W-1:0] v);
		logic signed [W_W-1:0] r;
		if (v > SAT_IN_W'(W_MAX))
			r = W_MAX;
		else if (v < SAT_IN_W'(W_MIN))
			r = W_MIN;
		else
			r = v[W_W-1:0];
		return r;
	endfunction

endpackage

/* design/cbe_cell.sv */
// One cell of the ring: holds one delayed sample and its tap weight.
// Depends on cbe_pkg.
module cbe_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cbe_pkg::cell_ctl_t             ctl,
	input  logic                           centre,
	input  logic signed [cbe_pkg::X_W-1:0] shift_x,
	input  logic signed [cbe_pkg::W_W-1:0] rot_w,
	input  logic signed [cbe_pkg::X_W-1:0] rot_x,
	output logic signed [cbe_pkg::W_W-1:0] w,
	output logic signed [cbe_pkg::X_W-1:0] x
);

	logic signed [cbe_pkg::W_W-1:0] w_q;
	logic signed [cbe_pkg::X_W-1:0] x_q;
	logic signed [cbe_pkg::W_W-1:0] w_init;

	assign w_init = centre ? cbe_pkg::ONE_Q20 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= w_init;
			x_q <= '0;
		end else begin
			priority if (ctl.clear) begin
				w_q <= w_init;
				x_q <= '0;
			end else if (ctl.load) begin
				x_q <= shift_x;
			end else if (ctl.rotate) begin
				w_q <= rot_w;
				x_q <= rot_x;
			end
		end
	end

	assign w = w_q;
	assign x = x_q;

endmodule

/* design/cbe_tap_unit.sv */
// Shared multiplier stage between the head and the tail of the ring: products
// for the dot product, and the rounded, saturated weight update.
// Depends on cbe_pkg.
module cbe_tap_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cbe_pkg::tap_ctl_t                 ctl,
	input  logic signed [cbe_pkg::W_W-1:0]    head_w,
	input  logic signed [cbe_pkg::X_W-1:0]    head_x,
	input  logic signed [cbe_pkg::MUE_W-1:0]  mue,
	output logic signed [cbe_pkg::W_W-1:0]    tail_w,
	output logic signed [cbe_pkg::X_W-1:0]    tail_x,
	output logic signed [cbe_pkg::PROD_W-1:0] prod,
	output logic                              prod_valid
);

	logic signed [cbe_pkg::MUE_W-1:0]  mul_a;
	logic signed [cbe_pkg::PROD_W-1:0] prod_s1;
	logic signed [cbe_pkg::W_W-1:0]    w_s1;
	logic signed [cbe_pkg::X_W-1:0]    x_s1;
	logic                              valid_s1;
	logic signed [cbe_pkg::PROD_W-1:0] rnd;
	logic signed [cbe_pkg::SAT_IN_W-1:0] diff;

	// The multiplier takes the weight in the dot product pass and mu*e in the update.
	assign mul_a = ctl.update ? mue : cbe_pkg::MUE_W'(head_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl.active && ctl.real_el;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= cbe_pkg::PROD_W'(mul_a) * cbe_pkg::PROD_W'(head_x);
		w_s1    <= head_w;
		x_s1    <= head_x;
	end

	assign rnd  = prod_s1 + (cbe_pkg::PROD_W'(1) <<< 30);
	assign diff = cbe_pkg::SAT_IN_W'(w_s1) - cbe_pkg::SAT_IN_W'(rnd >>> 31);

	assign tail_w     = ctl.update ? cbe_pkg::sat_w(diff) : w_s1;
	assign tail_x     = x_s1;
	assign prod       = prod_s1;
	assign prod_valid = valid_s1;

endmodule

/* design/cma_blind_equalizer_top.sv */
// Top level of the constant modulus blind equaliser: sequencer, error path,
// output register and the ring of cells. Depends on cbe_pkg, cbe_cell, cbe_tap_unit.
//
// Use: samples arrive on the s_ channel (s_tdata = sample, s_tlast = restore
// the reset weights and delay line after this item). One item of filter
// output per sample leaves on the m_ channel (m_tdata = filter_out, Q4.20).
// The step size mu is written through cfg_wen / cfg_wdata while the block is idle.
//
// The taps sit in a ring of TAPS cells with one shared multiplier stage
// between head and tail. A sample goes through an accept state, a rotation
// pass for the dot product, four states for y, y*y, the error and mu*e,
// a rotation pass for the weight update and a hand-off. A new item is taken
// only once the last one has been handed off; both passes of the ring go
// through one multiplier. The result appears on m_ in the cycle after the hand-off.
//
// Reset clears the delay line, sets the weights to a single centre tap of
// one and sets mu to 328. If the receiver stalls, the result waits in the
// output register while the next item is already taken and processed; that
// item then waits in the hand-off state until the register frees.
module cma_blind_equalizer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	input  logic        s_tlast,   // last_of_block
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [23:0] filter_out
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata  // step_size
);

	localparam int SQ_W  = 2 * cbe_pkg::W_W;
	localparam int Y2_W  = SQ_W - 20 + 1;
	localparam int EP_W  = cbe_pkg::W_W + Y2_W;
	localparam int E_W   = 31;

	cbe_pkg::state_t state_q;
	logic [cbe_pkg::RC_W-1:0] rot_q;
	logic last_q;
	logic done_q;
	logic [cbe_pkg::STEP_W-1:0] step_q;

	logic signed [cbe_pkg::ACC_W-1:0]  acc_q;
	logic signed [cbe_pkg::W_W-1:0]    y_q;
	logic signed [SQ_W-1:0]            sq_q;
	logic signed [EP_W-1:0]            ep_q;
	logic signed [cbe_pkg::MUE_W-1:0]  mue_q;

	logic signed [cbe_pkg::W_W-1:0] out_q;
	logic out_valid_q;

	logic accept;
	logic out_free;
	logic rot_end;

	logic signed [cbe_pkg::ACC_W-1:0]  acc_rnd;
	logic signed [SQ_W-1:0]            sq_rnd;
	logic signed [Y2_W-1:0]            y2m1;
	logic signed [EP_W-1:0]            ep_rnd;
	logic signed [E_W-1:0]             e_val;

	cbe_pkg::cell_ctl_t cell_ctl;
	cbe_pkg::tap_ctl_t  tap_ctl;

	logic signed [cbe_pkg::W_W-1:0] cell_w [cbe_pkg::TAPS];
	logic signed [cbe_pkg::X_W-1:0] cell_x [cbe_pkg::TAPS];
	logic signed [cbe_pkg::W_W-1:0] tail_w;
	logic signed [cbe_pkg::X_W-1:0] tail_x;
	logic signed [cbe_pkg::PROD_W-1:0] prod;
	logic prod_valid;

	assign s_tready = (state_q == cbe_pkg::ST_IDLE) && !done_q;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign rot_end  = (rot_q == cbe_pkg::RC_W'(cbe_pkg::TAPS));

	assign cell_ctl.load   = accept;
	assign cell_ctl.rotate = (state_q == cbe_pkg::ST_DOT) || (state_q == cbe_pkg::ST_UPD);
	assign cell_ctl.clear  = done_q && last_q;

	assign tap_ctl.active  = cell_ctl.rotate;
	assign tap_ctl.real_el = (rot_q < cbe_pkg::RC_W'(cbe_pkg::TAPS));
	assign tap_ctl.update  = (state_q == cbe_pkg::ST_UPD);

	// The ring: new samples enter at cell 0; rotation moves contents towards
	// cell 0 and the tap unit feeds the last cell.
	for (genvar i = 0; i < cbe_pkg::TAPS; i++) begin : g_cell
		logic signed [cbe_pkg::X_W-1:0] sx;
		logic signed [cbe_pkg::W_W-1:0] rw;
		logic signed [cbe_pkg::X_W-1:0] rx;
		if (i == 0) begin : g_first
			assign sx = s_tdata;
		end else begin : g_mid
			assign sx = cell_x[i-1];
		end
		if (i == cbe_pkg::TAPS - 1) begin : g_tail
			assign rw = tail_w;
			assign rx = tail_x;
		end else begin : g_next
			assign rw = cell_w[i+1];
			assign rx = cell_x[i+1];
		end
		cbe_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (cell_ctl),
			.centre  (i == cbe_pkg::TAPS / 2),
			.shift_x (sx),
			.rot_w   (rw),
			.rot_x   (rx),
			.w       (cell_w[i]),
			.x       (cell_x[i])
		);
	end

	cbe_tap_unit u_tap (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (tap_ctl),
		.head_w     (cell_w[0]),
		.head_x     (cell_x[0]),
		.mue        (mue_q),
		.tail_w     (tail_w),
		.tail_x     (tail_x),
		.prod       (prod),
		.prod_valid (prod_valid)
	);

	// Error path, rounded half up at each step as the arithmetic requires.
	assign acc_rnd = acc_q + (cbe_pkg::ACC_W'(1) <<< 14);
	assign sq_rnd  = sq_q + (SQ_W'(1) <<< 19);
	assign y2m1    = Y2_W'(sq_rnd >>> 20) - Y2_W'(cbe_pkg::ONE_Q20);
	assign ep_rnd  = ep_q + (EP_W'(1) <<< 19);
	assign e_val   = E_W'(ep_rnd >>> 20);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= cbe_pkg::STEP_RST;
		end else if (cfg_wen) begin
			step_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cbe_pkg::ST_IDLE;
			rot_q       <= '0;
			last_q      <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tready)
				out_valid_q <= 1'b0;
			// The finished result waits here until the output register frees.
			if (done_q && out_free) begin
				done_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end
			unique case (state_q)
				cbe_pkg::ST_IDLE: begin
					if (accept) begin
						last_q  <= s_tlast;
						rot_q   <= '0;
						state_q <= cbe_pkg::ST_DOT;
					end
				end
				cbe_pkg::ST_DOT: begin
					rot_q <= rot_q + 1'b1;
					if (rot_end)
						state_q <= cbe_pkg::ST_Y;
				end
				cbe_pkg::ST_Y:   state_q <= cbe_pkg::ST_SQ;
				cbe_pkg::ST_SQ:  state_q <= cbe_pkg::ST_ERR;
				cbe_pkg::ST_ERR: state_q <= cbe_pkg::ST_MUE;
				cbe_pkg::ST_MUE: begin
					rot_q   <= '0;
					state_q <= cbe_pkg::ST_UPD;
				end
				cbe_pkg::ST_UPD: begin
					rot_q <= rot_q + 1'b1;
					if (rot_end) begin
						done_q  <= 1'b1;
						state_q <= cbe_pkg::ST_IDLE;
					end
				end
				default: state_q <= cbe_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			acc_q <= '0;
		else if ((state_q == cbe_pkg::ST_DOT) && prod_valid)
			acc_q <= acc_q + cbe_pkg::ACC_W'(prod);
		if (state_q == cbe_pkg::ST_Y)
			y_q <= cbe_pkg::sat_w(cbe_pkg::SAT_IN_W'(acc_rnd >>> 15));
		if (state_q == cbe_pkg::ST_SQ)
			sq_q <= SQ_W'(y_q) * SQ_W'(y_q);
		if (state_q == cbe_pkg::ST_ERR)
			ep_q <= EP_W'(y_q) * EP_W'(y2m1);
		if (state_q == cbe_pkg::ST_MUE)
			mue_q <= $signed({{(cbe_pkg::MUE_W - cbe_pkg::STEP_W){1'b0}}, step_q})
				* cbe_pkg::MUE_W'(e_val);
		if (done_q && out_free)
			out_q <= y_q;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	// The rotation counter never runs past one full turn of the ring, which
	// is TAPS cells plus the multiplier stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		rot_q <= cbe_pkg::RC_W'(cbe_pkg::TAPS + 1))
		else $error("rotation counter overran the ring");

	// An accepted item always starts the dot product pass.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == cbe_pkg::ST_DOT)
		else $error("accepted item did not start the dot product");

	// No product is flagged valid in the y state, after the dot product pass.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cbe_pkg::ST_Y) |-> !prod_valid)
		else $error("stray product after dot product pass");

	// A result waiting for hand-off blocks the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !s_tready)
		else $error("input accepted while a result waits for hand-off");

endmodule
